/* hw/rtl/mer_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, control-word types and the microcode ROM of the midpoint
// ellipse rasterizer. No dependencies; used by mer_datapath and the top level.
package mer_pkg;

    localparam int COORD_BITS  = 11;
    localparam int RADIUS_BITS = 10;
    localparam int OUT_BITS    = COORD_BITS + 2;
    localparam int SQ_BITS     = 2 * RADIUS_BITS;
    localparam int TERM_BITS   = SQ_BITS + RADIUS_BITS + 2;
    localparam int MUL_BITS    = SQ_BITS + 2;
    localparam int PROD_BITS   = 2 * MUL_BITS;
    localparam int DEC_BITS    = PROD_BITS + 4;
    localparam int CFG_BITS    = COORD_BITS;
    localparam int CFG_IDX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_X = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_Y = 2'd3;

    // drawing phase
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD_START = 4'd1;
    localparam logic [OP_W-1:0] OP_SET_RXSQ   = 4'd2;
    localparam logic [OP_W-1:0] OP_SET_RYSQ   = 4'd3;
    localparam logic [OP_W-1:0] OP_INIT_TERMS = 4'd4;
    localparam logic [OP_W-1:0] OP_R1_MOVE    = 4'd5;
    localparam logic [OP_W-1:0] OP_R1_DEC     = 4'd6;
    localparam logic [OP_W-1:0] OP_R2_MOVE    = 4'd7;
    localparam logic [OP_W-1:0] OP_R2_DEC     = 4'd8;
    localparam logic [OP_W-1:0] OP_ENTER_R2   = 4'd9;
    localparam logic [OP_W-1:0] OP_D_LOAD     = 4'd10;
    localparam logic [OP_W-1:0] OP_D_ADD4     = 4'd11;
    localparam logic [OP_W-1:0] OP_D_SUB4     = 4'd12;
    localparam logic [OP_W-1:0] OP_FINISH     = 4'd13;

    // multiplier operand selects
    localparam int MS_W = 4;
    localparam logic [MS_W-1:0] MS_ZERO     = 4'd0;
    localparam logic [MS_W-1:0] MS_RADIUS_X = 4'd1;
    localparam logic [MS_W-1:0] MS_RADIUS_Y = 4'd2;
    localparam logic [MS_W-1:0] MS_RXSQ     = 4'd3;
    localparam logic [MS_W-1:0] MS_RYSQ     = 4'd4;
    localparam logic [MS_W-1:0] MS_ROW      = 4'd5;
    localparam logic [MS_W-1:0] MS_ODD      = 4'd6;
    localparam logic [MS_W-1:0] MS_BM1      = 4'd7;
    localparam logic [MS_W-1:0] MS_PROD     = 4'd8;

    // sequencer jumps
    localparam logic [1:0] JMP_NEXT      = 2'd0;
    localparam logic [1:0] JMP_ALWAYS    = 2'd1;
    localparam logic [1:0] JMP_UNLESS_R2 = 2'd2;

    // program addresses
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_BEGIN  = 5'd0;
    localparam logic [PC_W-1:0] PC_BG1    = 5'd1;
    localparam logic [PC_W-1:0] PC_BG2    = 5'd2;
    localparam logic [PC_W-1:0] PC_BG3    = 5'd3;
    localparam logic [PC_W-1:0] PC_STEP1  = 5'd4;
    localparam logic [PC_W-1:0] PC_S1B    = 5'd5;
    localparam logic [PC_W-1:0] PC_STEP2  = 5'd6;
    localparam logic [PC_W-1:0] PC_S2B    = 5'd7;
    localparam logic [PC_W-1:0] PC_CHECK  = 5'd8;
    localparam logic [PC_W-1:0] PC_T1     = 5'd9;
    localparam logic [PC_W-1:0] PC_T2     = 5'd10;
    localparam logic [PC_W-1:0] PC_T3     = 5'd11;
    localparam logic [PC_W-1:0] PC_T4     = 5'd12;
    localparam logic [PC_W-1:0] PC_T5     = 5'd13;
    localparam logic [PC_W-1:0] PC_FINISH = 5'd14;
    localparam logic [PC_W-1:0] PC_EMIT0  = 5'd15;
    localparam logic [PC_W-1:0] PC_EMIT1  = 5'd16;
    localparam logic [PC_W-1:0] PC_EMIT2  = 5'd17;
    localparam logic [PC_W-1:0] PC_EMIT3  = 5'd18;
    localparam logic [PC_W-1:0] PC_LAST   = PC_EMIT3;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [MS_W-1:0] mul_a;
        logic [MS_W-1:0] mul_b;
        logic [1:0]      jump;
        logic [PC_W-1:0] target;
        logic            emit;
        logic [1:0]      emit_k;
        logic            done;
    } mer_ctrl_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       r2_start;
        logic       fin;
    } mer_status_t;

    localparam mer_ctrl_t CTRL_IDLE = '{
        op: OP_NONE, mul_a: MS_ZERO, mul_b: MS_ZERO, jump: JMP_NEXT,
        target: PC_BEGIN, emit: 1'b0, emit_k: 2'd0, done: 1'b0
    };

    // Microcode ROM. The odd-square product is launched in the check step so
    // the region-two entry sequence finds it ready.
    function automatic mer_ctrl_t rom_word(input logic [PC_W-1:0] pc);
        mer_ctrl_t w;
        w = CTRL_IDLE;
        case (pc)
            PC_BEGIN:
            begin
                w.op = OP_LOAD_START;
                w.mul_a = MS_RADIUS_X;
                w.mul_b = MS_RADIUS_X;
            end
            PC_BG1:
            begin
                w.op = OP_SET_RXSQ;
                w.mul_a = MS_RADIUS_Y;
                w.mul_b = MS_RADIUS_Y;
            end
            PC_BG2:
            begin
                w.op = OP_SET_RYSQ;
                w.mul_a = MS_RXSQ;
                w.mul_b = MS_ROW;
            end
            PC_BG3:
            begin
                w.op = OP_INIT_TERMS;
                w.jump = JMP_ALWAYS;
                w.target = PC_CHECK;
            end
            PC_STEP1:
            begin
                w.op = OP_R1_MOVE;
            end
            PC_S1B:
            begin
                w.op = OP_R1_DEC;
                w.jump = JMP_ALWAYS;
                w.target = PC_CHECK;
            end
            PC_STEP2:
            begin
                w.op = OP_R2_MOVE;
            end
            PC_S2B:
            begin
                w.op = OP_R2_DEC;
            end
            PC_CHECK:
            begin
                w.mul_a = MS_ODD;
                w.mul_b = MS_ODD;
                w.jump = JMP_UNLESS_R2;
                w.target = PC_FINISH;
            end
            PC_T1:
            begin
                w.op = OP_ENTER_R2;
                w.mul_a = MS_RYSQ;
                w.mul_b = MS_PROD;
            end
            PC_T2:
            begin
                w.op = OP_D_LOAD;
                w.mul_a = MS_BM1;
                w.mul_b = MS_BM1;
            end
            PC_T3:
            begin
                w.mul_a = MS_RXSQ;
                w.mul_b = MS_PROD;
            end
            PC_T4:
            begin
                w.op = OP_D_ADD4;
                w.mul_a = MS_RXSQ;
                w.mul_b = MS_RYSQ;
            end
            PC_T5:
            begin
                w.op = OP_D_SUB4;
            end
            PC_FINISH:
            begin
                w.op = OP_FINISH;
            end
            PC_EMIT0:
            begin
                w.emit = 1'b1;
                w.emit_k = 2'd0;
            end
            PC_EMIT1:
            begin
                w.emit = 1'b1;
                w.emit_k = 2'd1;
            end
            PC_EMIT2:
            begin
                w.emit = 1'b1;
                w.emit_k = 2'd2;
            end
            PC_EMIT3:
            begin
                w.emit = 1'b1;
                w.emit_k = 2'd3;
                w.done = 1'b1;
            end
            default:
            begin
                w = CTRL_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/midpoint_ellipse_raster_unit.sv */
`timescale 1ns / 1ps
// Top level of the midpoint ellipse rasterizer: configuration registers,
// microcode sequencer and output register. Depends on mer_pkg and mer_datapath.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    begin_req
//   out       output     out_valid/out_ready  pixel_x, pixel_y, last_of_step, finished
//   cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A begin (longer when it enters region two at once) or a step (longer when region
// two starts) is stretched by any output stall; an advance while idle is taken and
// gives nothing. The single shared multiplier and the output register, which takes
// one pixel per cycle while the output does not stall, set their length. The next item
// is taken the cycle after the fourth pixel enters the output register.
// Reset leaves the block idle with its state and configuration registers at zero.
// cfg_ready is always high.
module midpoint_ellipse_raster_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 begin_req,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [mer_pkg::OUT_BITS-1:0]  pixel_x,
    output logic signed [mer_pkg::OUT_BITS-1:0]  pixel_y,
    output logic                                 last_of_step,
    output logic                                 finished,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mer_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [mer_pkg::CFG_BITS-1:0]         cfg_data
);

    logic [mer_pkg::COORD_BITS-1:0]      center_x_reg, center_y_reg;
    logic [mer_pkg::RADIUS_BITS-1:0]     radius_x_reg, radius_y_reg;

    logic [mer_pkg::PC_W-1:0]            pc_reg, pc_next;
    logic                                busy_reg, busy_next;
    mer_pkg::mer_ctrl_t                  cw, ctrl;
    mer_pkg::mer_status_t                status;
    logic                                stall;
    logic                                out_load;

    logic                                out_valid_reg;
    logic signed [mer_pkg::OUT_BITS-1:0] pixel_x_reg, pixel_y_reg;
    logic                                last_reg, fin_reg;
    logic signed [mer_pkg::OUT_BITS-1:0] dp_pixel_x, dp_pixel_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_x_reg <= '0;
            radius_y_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mer_pkg::REG_CENTER_X: center_x_reg <= cfg_data[mer_pkg::COORD_BITS-1:0];
                mer_pkg::REG_CENTER_Y: center_y_reg <= cfg_data[mer_pkg::COORD_BITS-1:0];
                mer_pkg::REG_RADIUS_X: radius_x_reg <= cfg_data[mer_pkg::RADIUS_BITS-1:0];
                mer_pkg::REG_RADIUS_Y: radius_y_reg <= cfg_data[mer_pkg::RADIUS_BITS-1:0];
                default:               center_x_reg <= center_x_reg;
            endcase
        end
    end

    // sequencer
    assign cw       = mer_pkg::rom_word(pc_reg);
    assign stall    = cw.emit && out_valid_reg && !out_ready;
    assign ctrl     = (busy_reg && !stall) ? cw : mer_pkg::CTRL_IDLE;
    assign in_ready = !busy_reg;
    assign out_load = busy_reg && cw.emit && !stall;

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (!busy_reg)
        begin
            if (in_valid)
            begin
                if (begin_req)
                begin
                    pc_next   = mer_pkg::PC_BEGIN;
                    busy_next = 1'b1;
                end
                else if (status.phase == mer_pkg::PH_ONE)
                begin
                    pc_next   = mer_pkg::PC_STEP1;
                    busy_next = 1'b1;
                end
                else if (status.phase == mer_pkg::PH_TWO)
                begin
                    pc_next   = mer_pkg::PC_STEP2;
                    busy_next = 1'b1;
                end
            end
        end
        else if (!stall)
        begin
            if (cw.done)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                case (cw.jump)
                    mer_pkg::JMP_ALWAYS:    pc_next = cw.target;
                    mer_pkg::JMP_UNLESS_R2: pc_next = status.r2_start ?
                                                      pc_reg + 1'b1 : cw.target;
                    default:                pc_next = pc_reg + 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= mer_pkg::PC_BEGIN;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the pixel until its transfer; a new one loads only into a free slot
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pixel_x_reg <= dp_pixel_x;
            pixel_y_reg <= dp_pixel_y;
            last_reg    <= &cw.emit_k;
            fin_reg     <= status.fin;
        end
    end

    mer_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .radius_x (radius_x_reg),
        .radius_y (radius_y_reg),
        .status   (status),
        .pixel_x  (dp_pixel_x),
        .pixel_y  (dp_pixel_y)
    );

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign last_of_step = last_reg;
    assign finished     = fin_reg;

`ifndef SYNTH
    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg <= mer_pkg::PC_LAST)
        else $error("step counter left the microprogram");

    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg && cw.emit))
        else $error("output register loaded outside an emit step");
`endif

endmodule

/* hw/rtl/mer_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the ellipse rasterizer: point and decision registers, one shared
// registered multiplier and the mirrored pixel adders. Driven by mer_pkg control words.
module mer_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mer_pkg::mer_ctrl_t                     ctrl,
    input  logic [mer_pkg::COORD_BITS-1:0]         center_x,
    input  logic [mer_pkg::COORD_BITS-1:0]         center_y,
    input  logic [mer_pkg::RADIUS_BITS-1:0]        radius_x,
    input  logic [mer_pkg::RADIUS_BITS-1:0]        radius_y,
    output mer_pkg::mer_status_t                   status,
    output logic signed [mer_pkg::OUT_BITS-1:0]    pixel_x,
    output logic signed [mer_pkg::OUT_BITS-1:0]    pixel_y
);

    logic [1:0]                          phase_reg, phase_next;
    logic [mer_pkg::RADIUS_BITS-1:0]     col_reg, col_next;
    logic [mer_pkg::RADIUS_BITS-1:0]     row_reg, row_next;
    logic [mer_pkg::TERM_BITS-1:0]       h_reg, h_next;
    logic [mer_pkg::TERM_BITS-1:0]       v_reg, v_next;
    logic signed [mer_pkg::DEC_BITS-1:0] d_reg, d_next;
    logic [mer_pkg::SQ_BITS-1:0]         rxsq_reg, rxsq_next;
    logic [mer_pkg::SQ_BITS-1:0]         rysq_reg, rysq_next;
    logic [mer_pkg::PROD_BITS-1:0]       prod_reg, prod_next;
    logic                                flag_reg, flag_next;
    logic                                fin_reg, fin_next;

    logic [mer_pkg::MUL_BITS-1:0]        mul_a, mul_b;
    logic [mer_pkg::RADIUS_BITS:0]       odd;
    logic [mer_pkg::RADIUS_BITS-1:0]     bm1;
    logic [mer_pkg::RADIUS_BITS-1:0]     col_inc;
    logic [mer_pkg::RADIUS_BITS-1:0]     row_dec;
    logic [mer_pkg::TERM_BITS-1:0]       rxsq2, rysq2;
    logic signed [mer_pkg::DEC_BITS-1:0] h_ext, v_ext, rxsq_ext, rysq_ext, prod_ext;
    logic signed [mer_pkg::DEC_BITS-1:0] r1_sum, r2_sum;
    logic [mer_pkg::OUT_BITS-1:0]        col_w, row_w;

    assign odd     = {col_reg, 1'b1};
    assign row_dec = row_reg - mer_pkg::RADIUS_BITS'(1);
    assign bm1     = (row_reg == '0) ? mer_pkg::RADIUS_BITS'(1) : row_dec;
    // saturate the column at its top value
    assign col_inc = (&col_reg) ? col_reg : col_reg + mer_pkg::RADIUS_BITS'(1);
    assign rxsq2   = mer_pkg::TERM_BITS'({rxsq_reg, 1'b0});
    assign rysq2   = mer_pkg::TERM_BITS'({rysq_reg, 1'b0});

    assign h_ext    = mer_pkg::DEC_BITS'(h_reg);
    assign v_ext    = mer_pkg::DEC_BITS'(v_reg);
    assign rxsq_ext = mer_pkg::DEC_BITS'(rxsq_reg);
    assign rysq_ext = mer_pkg::DEC_BITS'(rysq_reg);
    assign prod_ext = mer_pkg::DEC_BITS'(prod_reg);
    assign r1_sum   = rysq_ext + h_ext - (flag_reg ? v_ext : '0);
    assign r2_sum   = rxsq_ext - v_ext + (flag_reg ? h_ext : '0);

    always_comb
    begin
        case (ctrl.mul_a)
            mer_pkg::MS_RADIUS_X: mul_a = mer_pkg::MUL_BITS'(radius_x);
            mer_pkg::MS_RADIUS_Y: mul_a = mer_pkg::MUL_BITS'(radius_y);
            mer_pkg::MS_RXSQ:     mul_a = mer_pkg::MUL_BITS'(rxsq_reg);
            mer_pkg::MS_RYSQ:     mul_a = mer_pkg::MUL_BITS'(rysq_reg);
            mer_pkg::MS_ROW:      mul_a = mer_pkg::MUL_BITS'(row_reg);
            mer_pkg::MS_ODD:      mul_a = mer_pkg::MUL_BITS'(odd);
            mer_pkg::MS_BM1:      mul_a = mer_pkg::MUL_BITS'(bm1);
            mer_pkg::MS_PROD:     mul_a = prod_reg[mer_pkg::MUL_BITS-1:0];
            default:              mul_a = '0;
        endcase
        case (ctrl.mul_b)
            mer_pkg::MS_RADIUS_X: mul_b = mer_pkg::MUL_BITS'(radius_x);
            mer_pkg::MS_RADIUS_Y: mul_b = mer_pkg::MUL_BITS'(radius_y);
            mer_pkg::MS_RXSQ:     mul_b = mer_pkg::MUL_BITS'(rxsq_reg);
            mer_pkg::MS_RYSQ:     mul_b = mer_pkg::MUL_BITS'(rysq_reg);
            mer_pkg::MS_ROW:      mul_b = mer_pkg::MUL_BITS'(row_reg);
            mer_pkg::MS_ODD:      mul_b = mer_pkg::MUL_BITS'(odd);
            mer_pkg::MS_BM1:      mul_b = mer_pkg::MUL_BITS'(bm1);
            mer_pkg::MS_PROD:     mul_b = prod_reg[mer_pkg::MUL_BITS-1:0];
            default:              mul_b = '0;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        h_next     = h_reg;
        v_next     = v_reg;
        d_next     = d_reg;
        rxsq_next  = rxsq_reg;
        rysq_next  = rysq_reg;
        flag_next  = flag_reg;
        fin_next   = fin_reg;
        case (ctrl.op)
            mer_pkg::OP_LOAD_START:
            begin
                col_next = '0;
                row_next = radius_y;
            end
            mer_pkg::OP_SET_RXSQ:
            begin
                rxsq_next = prod_reg[mer_pkg::SQ_BITS-1:0];
            end
            mer_pkg::OP_SET_RYSQ:
            begin
                rysq_next = prod_reg[mer_pkg::SQ_BITS-1:0];
            end
            mer_pkg::OP_INIT_TERMS:
            begin
                // product holds rx^2 * ry here
                h_next = '0;
                v_next = {prod_reg[mer_pkg::TERM_BITS-2:0], 1'b0};
                d_next = (rysq_ext <<< 2) - (prod_ext <<< 2) + rxsq_ext;
                phase_next = mer_pkg::PH_ONE;
            end
            mer_pkg::OP_R1_MOVE:
            begin
                col_next  = col_inc;
                h_next    = h_reg + rysq2;
                flag_next = !d_reg[mer_pkg::DEC_BITS-1];
                if (!d_reg[mer_pkg::DEC_BITS-1])
                begin
                    row_next = row_dec;
                    v_next   = v_reg - rxsq2;
                end
            end
            mer_pkg::OP_R1_DEC:
            begin
                d_next = d_reg + (r1_sum <<< 2);
            end
            mer_pkg::OP_R2_MOVE:
            begin
                row_next  = row_dec;
                v_next    = v_reg - rxsq2;
                flag_next = d_reg[mer_pkg::DEC_BITS-1] || (d_reg == '0);
                if (d_reg[mer_pkg::DEC_BITS-1] || (d_reg == '0))
                begin
                    col_next = col_inc;
                    h_next   = h_reg + rysq2;
                end
            end
            mer_pkg::OP_R2_DEC:
            begin
                d_next = d_reg + (r2_sum <<< 2);
            end
            mer_pkg::OP_ENTER_R2:
            begin
                phase_next = mer_pkg::PH_TWO;
            end
            mer_pkg::OP_D_LOAD:
            begin
                d_next = prod_ext;
            end
            mer_pkg::OP_D_ADD4:
            begin
                d_next = d_reg + (prod_ext <<< 2);
            end
            mer_pkg::OP_D_SUB4:
            begin
                d_next = d_reg - (prod_ext <<< 2);
            end
            mer_pkg::OP_FINISH:
            begin
                fin_next = (phase_reg == mer_pkg::PH_TWO) && (row_reg == '0);
                if ((phase_reg == mer_pkg::PH_TWO) && (row_reg == '0))
                begin
                    phase_next = mer_pkg::PH_IDLE;
                end
            end
            default:
            begin
                d_next = d_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mer_pkg::PH_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            h_reg     <= '0;
            v_reg     <= '0;
            d_reg     <= '0;
            rxsq_reg  <= '0;
            rysq_reg  <= '0;
            prod_reg  <= '0;
            flag_reg  <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            h_reg     <= h_next;
            v_reg     <= v_next;
            d_reg     <= d_next;
            rxsq_reg  <= rxsq_next;
            rysq_reg  <= rysq_next;
            prod_reg  <= prod_next;
            flag_reg  <= flag_next;
            fin_reg   <= fin_next;
        end
    end

    assign status.phase    = phase_reg;
    assign status.r2_start = (phase_reg == mer_pkg::PH_ONE) && (h_reg >= v_reg);
    assign status.fin      = fin_reg;

    // mirror: bit 1 of the pixel index negates x, bit 0 negates y
    assign col_w = mer_pkg::OUT_BITS'(col_reg);
    assign row_w = mer_pkg::OUT_BITS'(row_reg);
    assign pixel_x = mer_pkg::OUT_BITS'(center_x) + (ctrl.emit_k[1] ? (~col_w + 1'b1) : col_w);
    assign pixel_y = mer_pkg::OUT_BITS'(center_y) + (ctrl.emit_k[0] ? (~row_w + 1'b1) : row_w);

`ifndef SYNTH
    // a restart reloads the row while the old phase is still held
    a_row_falls_in_r2: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mer_pkg::PH_TWO && $past(phase_reg) == mer_pkg::PH_TWO
         && $past(ctrl.op) != mer_pkg::OP_LOAD_START)
        |-> row_reg <= $past(row_reg))
        else $error("row grew while in region two");

    a_col_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(ctrl.op) != mer_pkg::OP_LOAD_START) |-> col_reg >= $past(col_reg))
        else $error("column fell outside an ellipse start");

    a_region_switch_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == mer_pkg::OP_FINISH)
        |-> !(phase_reg == mer_pkg::PH_ONE && h_reg >= v_reg))
        else $error("region one still active past its end at point finish");
`endif

endmodule

/* dv/mer_pixel_checker.sv */
`timescale 1ns / 1ps
// Pixel checker for the midpoint ellipse rasterizer: mirrors the register file,
// predicts every mirrored pixel of each accepted request and compares it with
// the output channel. Depends on mer_pkg.
module mer_pixel_checker
    import mer_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        begin_req,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic signed [OUT_BITS-1:0]  pixel_x,
    input  logic signed [OUT_BITS-1:0]  pixel_y,
    input  logic                        last_of_step,
    input  logic                        finished,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [CFG_BITS-1:0]         cfg_data,
    output int                          pixels_pending,
    output int                          fail_count
);

    typedef struct packed {
        logic signed [OUT_BITS-1:0] px;
        logic signed [OUT_BITS-1:0] py;
        logic                       last;
        logic                       fin;
    } pixel_t;

    localparam longint COL_MAX = (longint'(1) << RADIUS_BITS) - 1;

    pixel_t expected_pixels[$];

    logic [COORD_BITS-1:0]  center_x_q;
    logic [COORD_BITS-1:0]  center_y_q;
    logic [RADIUS_BITS-1:0] radius_x_q;
    logic [RADIUS_BITS-1:0] radius_y_q;
    logic [1:0]             draw_phase;
    longint                 col;
    longint                 row;
    longint                 h_term;
    longint                 v_term;
    longint                 dec;
    longint                 rx_sq;
    longint                 ry_sq;

    task automatic bump_column();
        if (col < COL_MAX)
            col++;
        h_term += 2 * ry_sq;
    endtask

    // Switch region or finish as due, then queue the four mirrored pixels of the current point.
    task automatic plot_point();
        logic   fin;
        longint dx;
        longint dy;
        pixel_t p;
        if (draw_phase == PH_ONE && h_term >= v_term)
        begin
            draw_phase = PH_TWO;
            dec = ry_sq * (2 * col + 1) * (2 * col + 1)
                + 4 * rx_sq * (row - 1) * (row - 1) - 4 * rx_sq * ry_sq;
        end
        fin = (draw_phase == PH_TWO) && (row <= 0);
        if (fin)
            draw_phase = PH_IDLE;
        for (int k = 0; k < 4; k++)
        begin
            dx = k[1] ? -col : col;
            dy = k[0] ? -row : row;
            p.px = OUT_BITS'(longint'(center_x_q) + dx);
            p.py = OUT_BITS'(longint'(center_y_q) + dy);
            p.last = (k == 3);
            p.fin = fin;
            expected_pixels.push_back(p);
        end
    endtask

    task automatic trace_request(input logic start);
        if (start)
        begin
            rx_sq = longint'(radius_x_q) * longint'(radius_x_q);
            ry_sq = longint'(radius_y_q) * longint'(radius_y_q);
            col = 0;
            row = longint'(radius_y_q);
            h_term = 0;
            v_term = 2 * rx_sq * row;
            dec = 4 * ry_sq - 4 * rx_sq * row + rx_sq;
            draw_phase = PH_ONE;
            plot_point();
        end
        else if (draw_phase == PH_ONE)
        begin
            bump_column();
            if (dec >= 0)
            begin
                row--;
                v_term -= 2 * rx_sq;
                dec += 4 * (ry_sq + h_term - v_term);
            end
            else
            begin
                dec += 4 * (ry_sq + h_term);
            end
            plot_point();
        end
        else if (draw_phase == PH_TWO)
        begin
            row--;
            v_term -= 2 * rx_sq;
            if (dec <= 0)
            begin
                bump_column();
                dec += 4 * (rx_sq - v_term + h_term);
            end
            else
            begin
                dec += 4 * (rx_sq - v_term);
            end
            plot_point();
        end
        // an advance while idle plots nothing
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            center_x_q = '0;
            center_y_q = '0;
            radius_x_q = '0;
            radius_y_q = '0;
            draw_phase = PH_IDLE;
            col = 0;
            row = 0;
            h_term = 0;
            v_term = 0;
            dec = 0;
            rx_sq = 0;
            ry_sq = 0;
            expected_pixels.delete();
            fail_count = 0;
            pixels_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CENTER_X: center_x_q = cfg_data;
                    REG_CENTER_Y: center_y_q = cfg_data;
                    REG_RADIUS_X: radius_x_q = cfg_data[RADIUS_BITS-1:0];
                    REG_RADIUS_Y: radius_y_q = cfg_data[RADIUS_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                trace_request(begin_req);
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected pixel x=%0d y=%0d", pixel_x, pixel_y);
                    fail_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_x !== want.px)
                    begin
                        $error("pixel_x: expected %0d, got %0d", want.px, pixel_x);
                        fail_count++;
                    end
                    if (pixel_y !== want.py)
                    begin
                        $error("pixel_y: expected %0d, got %0d", want.py, pixel_y);
                        fail_count++;
                    end
                    if (last_of_step !== want.last)
                    begin
                        $error("last_of_step: expected %0d, got %0d",
                               want.last, last_of_step);
                        fail_count++;
                    end
                    if (finished !== want.fin)
                    begin
                        $error("finished: expected %0d, got %0d", want.fin, finished);
                        fail_count++;
                    end
                end
            end
            pixels_pending <= expected_pixels.size();
        end
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Top of the ellipse rasterizer testbench: clock, reset, register writes,
// request and backpressure stimulus, verdict. Depends on mer_pkg,
// midpoint_ellipse_raster_unit and mer_pixel_checker.
module tb_top
    import mer_pkg::*;
;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic                        begin_req;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [OUT_BITS-1:0]  pixel_x;
    logic signed [OUT_BITS-1:0]  pixel_y;
    logic                        last_of_step;
    logic                        finished;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_BITS-1:0]     cfg_index;
    logic [CFG_BITS-1:0]         cfg_data;
    int                          pixels_pending;
    int                          fail_count;

    int   stall_pct;
    int   gap_pct;
    int   items_sent;
    logic hold_toggle;

    midpoint_ellipse_raster_unit uut (.*);

    mer_pixel_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Output backpressure; a toggle of hold_toggle starts a long hold-off.
    initial
    begin
        int   hold_left;
        logic seen_toggle;
        hold_left = 0;
        seen_toggle = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_toggle != seen_toggle)
            begin
                seen_toggle = hold_toggle;
                hold_left = 250;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic offer(input logic start);
        int gap;
        gap = 0;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        begin_req <= start;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Drop valid, drain all predicted pixels, then cover the longest request.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pixels_pending != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [CFG_BITS-1:0] cx, input logic [CFG_BITS-1:0] cy,
                                input logic [CFG_BITS-1:0] rx, input logic [CFG_BITS-1:0] ry);
        logic [CFG_IDX_BITS-1:0] idx  [4];
        logic [CFG_BITS-1:0]     vals [4];
        idx = '{REG_CENTER_X, REG_CENTER_Y, REG_RADIUS_X, REG_RADIUS_Y};
        vals = '{cx, cy, rx, ry};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_ellipse(input logic squeeze);
        logic [CFG_BITS-1:0] rx;
        logic [CFG_BITS-1:0] ry;
        int                  steps;
        settle();
        if ($urandom_range(9) == 0)
        begin
            rx = CFG_BITS'($urandom_range(1023));
            ry = CFG_BITS'($urandom_range(1023));
        end
        else
        begin
            rx = CFG_BITS'($urandom_range(12));
            ry = CFG_BITS'($urandom_range(12));
        end
        // the spare data bit is dropped by the radius registers
        if ($urandom_range(5) == 0)
            rx[CFG_BITS-1] = 1'b1;
        if ($urandom_range(5) == 0)
            ry[CFG_BITS-1] = 1'b1;
        set_geometry(CFG_BITS'($urandom_range(2047)), CFG_BITS'($urandom_range(2047)),
                     rx, ry);
        if (squeeze)
            hold_toggle <= ~hold_toggle;
        if (!squeeze && $urandom_range(7) == 0)
        begin
            repeat ($urandom_range(8, 2)) offer(1'($urandom_range(1)));
        end
        else
        begin
            offer(1'b1);
            steps = int'(rx[RADIUS_BITS-1:0]) + int'(ry[RADIUS_BITS-1:0])
                  + int'($urandom_range(2));
            if (steps > 40)
                steps = 40;
            // an occasional begin restarts the ellipse mid-way
            repeat (steps) offer($urandom_range(24) == 0);
        end
    endtask

    initial
    begin
        int gap_by_mode   [4];
        int stall_by_mode [4];
        int target;
        gap_by_mode = '{0, 59, 0, 28};
        stall_by_mode = '{0, 0, 59, 28};
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        begin_req <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_CENTER_X;
        cfg_data <= '0;
        stall_pct <= 0;
        hold_toggle <= 1'b0;
        gap_pct = 0;
        items_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // advance while idle, then a zero-radius ellipse that ends at once
        offer(1'b0);
        offer(1'b1);
        offer(1'b0);

        settle();
        set_geometry(11'd1000, 11'd600, 11'd3, 11'd2);
        offer(1'b1);
        repeat (6) offer(1'b0);

        // largest radii at the far corner; the spare radius bit is masked
        settle();
        set_geometry(11'd2047, 11'd2047, 11'd1023, 11'h7FF);
        offer(1'b1);
        offer(1'b0);
        offer(1'b0);

        // new radii mid-ellipse apply only from the next begin
        settle();
        set_geometry(11'd2047, 11'd2047, 11'd5, 11'd0);
        offer(1'b0);
        offer(1'b0);
        offer(1'b1);

        // origin corner with largest radii, restarted mid-ellipse
        settle();
        set_geometry(11'd0, 11'd0, 11'd1023, 11'd1023);
        offer(1'b1);
        offer(1'b0);
        offer(1'b1);
        offer(1'b0);

        // zero horizontal radius goes straight to region two
        settle();
        set_geometry(11'd40, 11'd2000, 11'd0, 11'd3);
        offer(1'b1);
        repeat (4) offer(1'b0);

        for (int m = 0; m < 4; m++)
        begin
            gap_pct = gap_by_mode[m];
            stall_pct <= stall_by_mode[m];
            target = items_sent + 40;
            run_ellipse(m == 0);
            while (items_sent < target)
                run_ellipse(1'b0);
        end

        settle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
